// File: hdl/smsc_pkg.sv
// Shared types and constants of the small-message send coalescer.
// This package has no dependencies. The top level imports it.
package smsc_pkg;

    localparam int LEN_BITS     = 20;
    localparam int FILL_BITS    = 16;
    localparam int HEADER_BYTES = 8;
    localparam int OVERRIDE_AT  = 4;
    localparam int OVR_BYTES    = 4;
    localparam logic [FILL_BITS-1:0] LIMIT_RESET = 16'd8192;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SMALL = 2'd1,
        MODE_LARGE = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    typedef enum logic {
        IN_BYTE      = 1'b0,
        IN_BATCH_END = 1'b1
    } in_kind_t;

    typedef enum logic {
        OUT_DATA    = 1'b0,
        OUT_SEG_END = 1'b1
    } out_kind_t;

    typedef struct packed {
        out_kind_t           kind;
        logic [7:0]          data;
        logic [LEN_BITS-1:0] seg_len;
    } result_t;

endpackage

// File: hdl/small_message_send_coalescer_unit.sv
// Top level of the small-message send coalescer: segment packing logic and
// a four-entry result queue. Depends on smsc_pkg.

// One beat enters per cycle while s_tready is high. Each byte beat gives zero,
// one or two result beats, and the segment logic between the input port and
// the result queue is a single pass of compares and adds. Results drain
// through a four-entry queue at one beat per cycle while m_tready is high; the
// input is ready while at least two entries are free, so a byte beat that also
// closes a segment takes a second queue entry, which can show upstream as a
// stall when the output side runs at full speed. A batch-end beat gives at most
// one segment-end beat. Segment-end beats carry the segment length in
// seg_length with the byte set to zero; data beats carry seg_length zero.
module small_message_send_coalescer_unit
    import smsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // coalesce_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // data_byte[7:0], msg_first[8],
                                      // msg_length[28:9], override_id[60:29]
    input  logic        s_tuser,      // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // out_byte[7:0], seg_length[27:8]
    output logic        m_tuser       // out_kind
);

    logic [FILL_BITS-1:0] limit_reg;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [LEN_BITS-1:0]  pos_reg, pos_next;
    mode_t                mode_reg, mode_next;

    result_t              queue_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    // Input fields
    in_kind_t            in_kind;
    logic [7:0]          in_byte;
    logic                in_first;
    logic [LEN_BITS-1:0] in_len;
    logic [31:0]         in_ovr;

    assign in_kind  = in_kind_t'(s_tuser);
    assign in_byte  = s_tdata[7:0];
    assign in_first = s_tdata[8];
    assign in_len   = s_tdata[LEN_BITS+8:9];
    assign in_ovr   = s_tdata[LEN_BITS+40:LEN_BITS+9];

    logic in_fire, out_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Results of the current beat
    result_t res0, res1;
    logic [1:0] res_cnt;

    // Working values
    logic [LEN_BITS-1:0]  pos_a, pos_inc;
    mode_t                mode_a;
    logic [FILL_BITS-1:0] fill_a, fill_inc;
    logic                 pre_close;
    logic [LEN_BITS-1:0]  pre_len;
    logic [FILL_BITS:0]   room;
    logic [7:0]           out_b;
    logic [1:0]           ovr_sel;
    logic [LEN_BITS-1:0]  ovr_off;
    logic [LEN_BITS-1:0]  limit_ext;

    assign limit_ext = LEN_BITS'(limit_reg);

    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        mode_next = mode_reg;
        res0      = '{kind: OUT_DATA, data: 8'd0, seg_len: '0};
        res1      = '{kind: OUT_DATA, data: 8'd0, seg_len: '0};
        res_cnt   = 2'd0;
        pos_a     = pos_reg;
        mode_a    = mode_reg;
        fill_a    = fill_reg;
        pre_close = 1'b0;
        pre_len   = '0;
        room      = {1'b0, limit_reg} - {1'b0, fill_reg};
        out_b     = in_byte;
        ovr_off   = pos_reg - LEN_BITS'(OVERRIDE_AT);
        ovr_sel   = ovr_off[1:0];
        pos_inc   = pos_reg + LEN_BITS'(1);
        fill_inc  = fill_reg + FILL_BITS'(1);

        if (in_kind == IN_BATCH_END)
        begin
            if (fill_reg != '0)
            begin
                res0      = '{kind: OUT_SEG_END, data: 8'd0, seg_len: LEN_BITS'(fill_reg)};
                res_cnt   = 2'd1;
                fill_next = '0;
            end
        end
        else
        begin
            if (in_first)
            begin
                // An unfinished large message is closed with what was sent.
                // The open coalesced segment is always empty in large mode.
                if (mode_reg == MODE_LARGE && pos_reg != '0)
                begin
                    pre_close = 1'b1;
                    pre_len   = pos_reg;
                end
                pos_a = '0;
                if (in_len < LEN_BITS'(HEADER_BYTES))
                begin
                    mode_a = MODE_DROP;
                end
                else if (in_len <= limit_ext)
                begin
                    mode_a = MODE_SMALL;
                    // Room is counted only when the fill is within the limit.
                    if (fill_reg != '0 && !room[FILL_BITS]
                        && room < (FILL_BITS+1)'(HEADER_BYTES))
                    begin
                        pre_close = 1'b1;
                        pre_len   = LEN_BITS'(fill_reg);
                        fill_a    = '0;
                    end
                end
                else
                begin
                    mode_a = MODE_LARGE;
                    if (fill_reg != '0)
                    begin
                        pre_close = 1'b1;
                        pre_len   = LEN_BITS'(fill_reg);
                        fill_a    = '0;
                    end
                end
                ovr_off  = -LEN_BITS'(OVERRIDE_AT);
                ovr_sel  = ovr_off[1:0];
                pos_inc  = LEN_BITS'(1);
                fill_inc = fill_a + FILL_BITS'(1);
            end

            mode_next = mode_a;
            pos_next  = pos_a;
            fill_next = fill_a;

            if (pre_close)
            begin
                res0    = '{kind: OUT_SEG_END, data: 8'd0, seg_len: pre_len};
                res_cnt = 2'd1;
            end

            if (mode_a == MODE_SMALL || mode_a == MODE_LARGE)
            begin
                if (in_ovr != '0 && pos_a >= LEN_BITS'(OVERRIDE_AT)
                    && pos_a < LEN_BITS'(OVERRIDE_AT + OVR_BYTES))
                begin
                    out_b = in_ovr[{ovr_sel, 3'b000} +: 8];
                end

                if (pre_close)
                begin
                    res1 = '{kind: OUT_DATA, data: out_b, seg_len: '0};
                end
                else
                begin
                    res0 = '{kind: OUT_DATA, data: out_b, seg_len: '0};
                end
                res_cnt  = pre_close ? 2'd2 : 2'd1;
                pos_next = pos_inc;

                if (mode_a == MODE_SMALL)
                begin
                    fill_next = fill_inc;
                    if (fill_inc >= limit_reg && !pre_close)
                    begin
                        res1      = '{kind: OUT_SEG_END, data: 8'd0,
                                      seg_len: LEN_BITS'(fill_inc)};
                        res_cnt   = 2'd2;
                        fill_next = '0;
                    end
                    if (pos_inc >= in_len)
                    begin
                        mode_next = MODE_IDLE;
                        pos_next  = '0;
                    end
                end
                else if (pos_inc >= in_len && !pre_close)
                begin
                    res1      = '{kind: OUT_SEG_END, data: 8'd0, seg_len: pos_inc};
                    res_cnt   = 2'd2;
                    mode_next = MODE_IDLE;
                    pos_next  = '0;
                end
            end
        end
    end

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_BITS'(res_cnt);
            count_next  = count_reg + (QPTR_BITS+1)'(res_cnt);
        end
        if (out_fire)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_BITS'(1);
            count_next  = count_next - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            fill_reg   <= '0;
            pos_reg    <= '0;
            mode_reg   <= MODE_IDLE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (in_fire && res_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= res1;
        end
    end

    // Two free entries are needed for a beat that may give two results.
    assign s_tready = count_reg <= (QPTR_BITS+1)'(QDEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tdata  = {4'd0, queue_reg[rd_ptr_reg].seg_len, queue_reg[rd_ptr_reg].data};

endmodule
